@@ sv/esmt_pkg.sv @@
`timescale 1ns / 1ps

package esmt_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int ROUTE_COUNT    = 8;
  localparam int KEY_W          = 8;
  localparam int SLOT_IDX_W     = 5;
  localparam logic [KEY_W-1:0] WILDCARD_KEY = 8'hFF;

  localparam logic [1:0] FN_SUB       = 2'd0;
  localparam logic [1:0] FN_UNSUB     = 2'd1;
  localparam logic [1:0] FN_UNSUB_ALL = 2'd2;
  localparam logic [1:0] FN_PUB       = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MATCH  = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_PROTECTED = 3'd5;

  // captured input item, broadcast to every cell
  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] domain;
    logic [KEY_W-1:0] device_key;
    logic [KEY_W-1:0] channel;
    logic [KEY_W-1:0] event_code;
    logic             inline_flag;
    logic             has_handler;
    logic [7:0]       route_bits;
    logic [7:0]       static_action;
    logic [7:0]       dynamic_action;
    logic             user_flag;
    logic [7:0]       slot_id;
  } query_t;

  // one stored subscription, 58 bits
  typedef struct packed {
    logic [KEY_W-1:0] domain;
    logic [KEY_W-1:0] device_key;
    logic [KEY_W-1:0] channel;
    logic [KEY_W-1:0] event_code;
    logic             inline_flag;
    logic [7:0]       route_bits;
    logic [7:0]       static_action;
    logic [7:0]       dynamic_action;
    logic             user_flag;
  } entry_t;

  typedef struct packed {
    logic sub_mode;   // scan looks for a free cell instead of a match
    logic pass;       // 0: inline matches, 1: queued matches
    logic tok_load;   // put the scan token on the first cell
    logic tok_adv;    // hand the token to the next cell
    logic write;      // store query in the cell holding a selected token
    logic clear_id;   // free the cell addressed by slot_id
    logic clear_user; // free every user cell
  } cell_ctl_t;

  typedef struct packed {
    logic                  token;
    logic                  sel;
    logic                  id_used;
    logic                  id_user;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  inline_flag;
    logic [7:0]            route_bits;
    logic [7:0]            dynamic_action;
    logic [7:0]            static_action;
  } cell_out_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  inline_flag;
    logic [7:0]            routes;
    logic [7:0]            dyn;
    logic [7:0]            stc;
    logic                  last;
  } res_t;

  function automatic logic key_hit(input logic [KEY_W-1:0] want, input logic [KEY_W-1:0] got);
    return (want == WILDCARD_KEY) || (want == got);
  endfunction

endpackage

@@ sv/event_subscription_match_table.sv @@
// Subscription table built as a chain of SLOT_COUNT cells; a one-hot scan token walks the chain.
// Unsubscribe, unsubscribe-all-user and a rejected subscribe: result from the execute state, with no token walk.
// Subscribe: the result waits on the token walk to the lowest free cell.
// Publish: two passes, one cell per cycle unless a held match waits on an output stall.
// One item at a time; the next item is accepted once the final result is in the output register.
// Reset clears every used bit and the output valid flag at once; no clearing pass is needed.
`timescale 1ns / 1ps

module event_subscription_match_table #(
  parameter int SLOT_COUNT = esmt_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] domain,
  input  logic [7:0] device_key,
  input  logic [7:0] channel,
  input  logic [7:0] event_code,
  input  logic       inline_flag,
  input  logic       has_handler,
  input  logic [7:0] route_bits,
  input  logic [7:0] static_action,
  input  logic [7:0] dynamic_action,
  input  logic       user_flag,
  input  logic [7:0] slot_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [4:0] slot_index,
  output logic       match_inline,
  output logic [7:0] match_routes,
  output logic [7:0] match_dynamic_action,
  output logic [7:0] match_static_action,
  output logic       last
);
  import esmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  query_t     q;
  logic       pass;
  logic       pass_next;
  logic       pend_valid;
  logic       pend_valid_next;
  res_t       pend;
  res_t       pend_next;
  res_t       o_res;
  logic       o_valid;
  logic       ld;
  res_t       ld_res;
  logic       out_free;

  cell_ctl_t  ctl;
  cell_out_t  co [SLOT_COUNT];
  logic       tin [SLOT_COUNT];

  res_t       found;
  logic       any_sel;
  logic       id_used;
  logic       id_user;
  logic       last_token;
  logic       sub_ok;
  logic       protect;
  logic       advance;

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign tin[g] = 1'b0;
      end else begin : g_link
        assign tin[g] = co[g-1].token;
      end
      esmt_cell #(.CELL_INDEX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .qry      (q),
        .token_in (tin[g]),
        .co       (co[g])
      );
    end
  endgenerate

  always_comb begin
    found   = '0;
    any_sel = 1'b0;
    id_used = 1'b0;
    id_user = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      any_sel           = any_sel | co[i].sel;
      id_used           = id_used | co[i].id_used;
      id_user           = id_user | co[i].id_user;
      found.slot        = found.slot | co[i].slot;
      found.inline_flag = found.inline_flag | co[i].inline_flag;
      found.routes      = found.routes | co[i].route_bits;
      found.dyn         = found.dyn | co[i].dynamic_action;
      found.stc         = found.stc | co[i].static_action;
    end
    found.status = ST_OK;
    last_token   = co[SLOT_COUNT-1].token;
  end

  always_comb begin
    sub_ok = (q.has_handler || (q.route_bits != 8'd0) || (q.static_action != 8'd0) ||
              (q.dynamic_action != 8'd0)) &&
             (!q.inline_flag || (q.has_handler && (q.route_bits == 8'd0) &&
                                 (q.static_action == 8'd0) && (q.dynamic_action == 8'd0))) &&
             ((q.route_bits >> ROUTE_COUNT) == 8'd0) &&
             !(q.user_flag && q.has_handler);
    protect = q.user_flag && !id_user;
  end

  assign out_free = !o_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    pass_next       = pass;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    ld              = 1'b0;
    ld_res          = '0;
    advance         = 1'b0;
    ctl             = '0;
    ctl.sub_mode    = (q.func == FN_SUB);
    ctl.pass        = pass;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (q.func)
          FN_SUB: begin
            if (!sub_ok) begin
              if (out_free) begin
                ld            = 1'b1;
                ld_res.status = ST_INVALID;
                ld_res.last   = 1'b1;
                state_next    = S_IDLE;
              end
            end else begin
              ctl.tok_load = 1'b1;
              pass_next    = 1'b0;
              state_next   = S_SCAN;
            end
          end
          FN_UNSUB: begin
            if (out_free) begin
              ld          = 1'b1;
              ld_res.last = 1'b1;
              if (!id_used) begin
                ld_res.status = ST_NOT_FOUND;
              end else if (protect) begin
                ld_res.status = ST_PROTECTED;
              end else begin
                ld_res.status = ST_OK;
                ctl.clear_id  = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          FN_UNSUB_ALL: begin
            if (out_free) begin
              ctl.clear_user = 1'b1;
              ld             = 1'b1;
              ld_res.status  = ST_OK;
              ld_res.last    = 1'b1;
              state_next     = S_IDLE;
            end
          end
          FN_PUB: begin
            ctl.tok_load    = 1'b1;
            pass_next       = 1'b0;
            pend_valid_next = 1'b0;
            state_next      = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (ctl.sub_mode) begin
          if (any_sel) begin
            if (out_free) begin
              ctl.write     = 1'b1;
              ld            = 1'b1;
              ld_res.status = ST_OK;
              ld_res.slot   = found.slot;
              ld_res.last   = 1'b1;
              state_next    = S_IDLE;
            end
          end else begin
            advance = 1'b1;
          end
        end else if (any_sel) begin
          // one match is held back so the final one can carry last
          if (!pend_valid) begin
            pend_valid_next = 1'b1;
            pend_next       = found;
            advance         = 1'b1;
          end else if (out_free) begin
            ld        = 1'b1;
            ld_res    = pend;
            pend_next = found;
            advance   = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (last_token) begin
            if (!ctl.sub_mode && !pass) begin
              ctl.tok_load = 1'b1;
              pass_next    = 1'b1;
            end else begin
              state_next = S_DONE;
            end
          end else begin
            ctl.tok_adv = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ld = 1'b1;
          if (ctl.sub_mode) begin
            ld_res.status = ST_FULL;
          end else if (pend_valid) begin
            ld_res = pend;
          end else begin
            ld_res.status = ST_NO_MATCH;
          end
          ld_res.last = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pass       <= 1'b0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      pass       <= pass_next;
      pend_valid <= pend_valid_next;
      if (ld) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (ld) begin
      o_res <= ld_res;
    end
    if (in_valid && in_ready) begin
      q.func           <= func;
      q.domain         <= domain;
      q.device_key     <= device_key;
      q.channel        <= channel;
      q.event_code     <= event_code;
      q.inline_flag    <= inline_flag;
      q.has_handler    <= has_handler;
      q.route_bits     <= route_bits;
      q.static_action  <= static_action;
      q.dynamic_action <= dynamic_action;
      q.user_flag      <= user_flag;
      q.slot_id        <= slot_id;
    end
  end

  assign out_valid            = o_valid;
  assign status               = o_res.status;
  assign slot_index           = o_res.slot;
  assign match_inline         = o_res.inline_flag;
  assign match_routes         = o_res.routes;
  assign match_dynamic_action = o_res.dyn;
  assign match_static_action  = o_res.stc;
  assign last                 = o_res.last;

endmodule

@@ sv/esmt_cell.sv @@
`timescale 1ns / 1ps

module esmt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  esmt_pkg::cell_ctl_t ctl,
  input  esmt_pkg::query_t   qry,
  input  logic               token_in,
  output esmt_pkg::cell_out_t co
);
  import esmt_pkg::*;

  logic   used;
  logic   token;
  entry_t ent;
  logic   key_ok;
  logic   cand;
  logic   sel;
  logic   id_hit;

  always_comb begin
    key_ok = key_hit(ent.domain, qry.domain) && key_hit(ent.device_key, qry.device_key) &&
             key_hit(ent.channel, qry.channel) && key_hit(ent.event_code, qry.event_code);
    if (ctl.sub_mode) begin
      cand = !used;
    end else begin
      cand = used && (ent.inline_flag == !ctl.pass) && key_ok;
    end
    sel    = token && cand;
    id_hit = (qry.slot_id == 8'(CELL_INDEX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      token <= 1'b0;
    end else begin
      if (ctl.tok_load) begin
        token <= 1'(CELL_INDEX == 0);
      end else if (ctl.tok_adv) begin
        token <= token_in;
      end
      if (ctl.write && sel) begin
        used <= 1'b1;
      end else if ((ctl.clear_id && id_hit) || (ctl.clear_user && used && ent.user_flag)) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write && sel) begin
      ent.domain         <= qry.domain;
      ent.device_key     <= qry.device_key;
      ent.channel        <= qry.channel;
      ent.event_code     <= qry.event_code;
      ent.inline_flag    <= qry.inline_flag;
      ent.route_bits     <= qry.route_bits;
      ent.static_action  <= qry.static_action;
      ent.dynamic_action <= qry.dynamic_action;
      ent.user_flag      <= qry.user_flag;
    end
  end

  // data is gated by sel so the top level can OR all cells together
  always_comb begin
    co.token          = token;
    co.sel            = sel;
    co.id_used        = id_hit && used;
    co.id_user        = id_hit && used && ent.user_flag;
    co.slot           = sel ? SLOT_IDX_W'(CELL_INDEX) : '0;
    co.inline_flag    = sel ? ent.inline_flag : 1'b0;
    co.route_bits     = sel ? ent.route_bits : '0;
    co.dynamic_action = sel ? ent.dynamic_action : '0;
    co.static_action  = sel ? ent.static_action : '0;
  end

endmodule

@@ sv/esmt_checker.sv @@
`timescale 1ns / 1ps

module esmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [4:0] slot_index,
  input logic       last
);
  import esmt_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index) && $stable(last))
    else $error("result changed while stalled");

  // one item at a time: no acceptance right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // only publish matches come before the final result
  a_non_last_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OK)
    else $error("non-final result with error status");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind event_subscription_match_table esmt_checker u_esmt_checker (.*);

@@ test/event_subscription_match_table_tb.sv @@
`timescale 1ns / 1ps

module event_subscription_match_table_tb;
  import esmt_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int PHASE_ITEMS   = 64;

  typedef struct packed {
    query_t q;
    logic   typed;  // want holds a hand-written reply
    res_t   want;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] func;
  logic [7:0] domain;
  logic [7:0] device_key;
  logic [7:0] channel;
  logic [7:0] event_code;
  logic       inline_flag;
  logic       has_handler;
  logic [7:0] route_bits;
  logic [7:0] static_action;
  logic [7:0] dynamic_action;
  logic       user_flag;
  logic [7:0] slot_id;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [2:0] status;
  logic [4:0] slot_index;
  logic       match_inline;
  logic [7:0] match_routes;
  logic [7:0] match_dynamic_action;
  logic [7:0] match_static_action;
  logic       last;

  // shadow copy of the subscription table
  entry_t           shadow_entry [SLOTS];
  logic [SLOTS-1:0] shadow_used = '0;
  res_t             awaited_replies [$];
  dir_row_t         dir_rows [$];

  int fail_count     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  event_subscription_match_table #(.SLOT_COUNT(SLOTS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic query_t sub_q(input logic [31:0] keys, input logic inl, hnd,
                                   input logic [7:0] rt, stc, dyn, input logic usr);
    query_t q;
    q = '0;
    q.func = FN_SUB;
    {q.domain, q.device_key, q.channel, q.event_code} = keys;
    q.inline_flag    = inl;
    q.has_handler    = hnd;
    q.route_bits     = rt;
    q.static_action  = stc;
    q.dynamic_action = dyn;
    q.user_flag      = usr;
    return q;
  endfunction

  function automatic query_t unsub_q(input logic [1:0] fn, input logic [7:0] id,
                                     input logic usr);
    query_t q;
    q = '0;
    q.func      = fn;
    q.slot_id   = id;
    q.user_flag = usr;
    return q;
  endfunction

  function automatic query_t pub_q(input logic [31:0] keys);
    query_t q;
    q = '0;
    q.func = FN_PUB;
    {q.domain, q.device_key, q.channel, q.event_code} = keys;
    return q;
  endfunction

  function automatic dir_row_t dir_row(input query_t q, input logic typed,
                                       input logic [2:0] st, input logic [4:0] slot);
    dir_row_t r;
    r.q           = q;
    r.typed       = typed;
    r.want        = '0;
    r.want.status = st;
    r.want.slot   = slot;
    r.want.last   = 1'b1;
    return r;
  endfunction

  // keys cluster on a few values so that publishes hit stored subscriptions
  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(0, 2));
    if (r < 70) return WILDCARD_KEY;
    return 8'($urandom);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int     pick;
    int     kind;
    q.domain         = pick_key();
    q.device_key     = pick_key();
    q.channel        = pick_key();
    q.event_code     = pick_key();
    q.inline_flag    = 1'($urandom);
    q.has_handler    = 1'($urandom);
    q.route_bits     = 8'($urandom);
    q.static_action  = 8'($urandom);
    q.dynamic_action = 8'($urandom);
    q.user_flag      = 1'($urandom);
    q.slot_id        = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      q.func = FN_SUB;
      kind = $urandom_range(0, 9);
      if (kind >= 3 && kind < 9) begin
        q.inline_flag = 1'b0;
        if ($urandom_range(0, 1)) q.route_bits = '0;
        if ($urandom_range(0, 1)) q.static_action = '0;
        if ($urandom_range(0, 1)) q.dynamic_action = '0;
      end
      if (kind < 3) begin
        // inline: handler only
        q.inline_flag    = 1'b1;
        q.has_handler    = 1'b1;
        q.route_bits     = '0;
        q.static_action  = '0;
        q.dynamic_action = '0;
        q.user_flag      = 1'b0;
      end else if (kind < 6) begin
        q.user_flag = 1'b0;
      end else if (kind < 9) begin
        // user entry: no handler, needs a route or an action
        q.has_handler = 1'b0;
        q.user_flag   = 1'b1;
        if (q.route_bits == 0 && q.static_action == 0 && q.dynamic_action == 0)
          q.route_bits = 8'h01;
      end
    end else if (pick < 65) begin
      q.func = FN_UNSUB;
      if ($urandom_range(0, 99) < 85) q.slot_id = 8'($urandom_range(0, SLOTS - 1));
    end else if (pick < 70) begin
      q.func = FN_UNSUB_ALL;
    end else begin
      q.func = FN_PUB;
    end
    return q;
  endfunction

  function automatic logic slot_matches(input entry_t e, input query_t q);
    return (e.domain == WILDCARD_KEY || e.domain == q.domain) &&
           (e.device_key == WILDCARD_KEY || e.device_key == q.device_key) &&
           (e.channel == WILDCARD_KEY || e.channel == q.channel) &&
           (e.event_code == WILDCARD_KEY || e.event_code == q.event_code);
  endfunction

  // Updates the shadow table and queues the replies the item should produce.
  task automatic apply_to_shadow_table(input query_t q, input logic use_typed,
                                       input res_t typed_res);
    res_t             r;
    entry_t           e;
    logic             any_target;
    logic             inline_legal;
    logic [SLOTS-1:0] hits;
    int               total;
    int               n;
    r      = '0;
    r.last = 1'b1;
    total  = 0;
    case (q.func)
      FN_SUB: begin
        any_target = q.has_handler || q.route_bits != 0 || q.static_action != 0 ||
                     q.dynamic_action != 0;
        inline_legal = !q.inline_flag || (q.has_handler && q.route_bits == 0 &&
                       q.static_action == 0 && q.dynamic_action == 0);
        if (!any_target || !inline_legal || (q.route_bits >> ROUTE_COUNT) != 0 ||
            (q.user_flag && q.has_handler)) begin
          r.status = ST_INVALID;
        end else begin
          e.domain         = q.domain;
          e.device_key     = q.device_key;
          e.channel        = q.channel;
          e.event_code     = q.event_code;
          e.inline_flag    = q.inline_flag;
          e.route_bits     = q.route_bits;
          e.static_action  = q.static_action;
          e.dynamic_action = q.dynamic_action;
          e.user_flag      = q.user_flag;
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (r.status == ST_FULL && !shadow_used[i]) begin
              shadow_entry[i] = e;
              shadow_used[i]  = 1'b1;
              r.status        = ST_OK;
              r.slot          = 5'(i);
            end
          end
        end
      end
      FN_UNSUB: begin
        if (q.slot_id >= SLOTS || !shadow_used[q.slot_id[4:0]])
          r.status = ST_NOT_FOUND;
        else if (q.user_flag && !shadow_entry[q.slot_id[4:0]].user_flag)
          r.status = ST_PROTECTED;
        else
          shadow_used[q.slot_id[4:0]] = 1'b0;
      end
      FN_UNSUB_ALL: begin
        for (int i = 0; i < SLOTS; i++)
          if (shadow_used[i] && shadow_entry[i].user_flag) shadow_used[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          hits[i] = shadow_used[i] && slot_matches(shadow_entry[i], q);
        total = $countones(hits);
        if (total == 0) r.status = ST_NO_MATCH;
        n = 0;
        // inline matches first, then queued ones
        for (int p = 0; p < 2; p++) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (hits[i] && shadow_entry[i].inline_flag == (p == 0)) begin
              n++;
              r.slot        = 5'(i);
              r.inline_flag = shadow_entry[i].inline_flag;
              r.routes      = shadow_entry[i].route_bits;
              r.dyn         = shadow_entry[i].dynamic_action;
              r.stc         = shadow_entry[i].static_action;
              r.last        = (n == total);
              awaited_replies.push_back(r);
            end
          end
        end
      end
    endcase
    if (q.func != FN_PUB || total == 0)
      awaited_replies.push_back(use_typed ? typed_res : r);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input query_t q, input logic use_typed, input res_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    {func, domain, device_key, channel, event_code, inline_flag, has_handler, route_bits,
     static_action, dynamic_action, user_flag, slot_id} = q;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_shadow_table(q, use_typed, typed_res);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] got);
    if (got !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin : check_reply
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $error("reply with none expected: status %0d slot %0d", status, slot_index);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", 8'(want.status), 8'(status));
        check_field("slot_index", 8'(want.slot), 8'(slot_index));
        check_field("match_inline", 8'(want.inline_flag), 8'(match_inline));
        check_field("match_routes", want.routes, match_routes);
        check_field("match_dynamic_action", want.dyn, match_dynamic_action);
        check_field("match_static_action", want.stc, match_static_action);
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("event_subscription_match_table_tb: FAIL");
      $finish;
    end
  end

  initial begin
    query_t q;
    rst      = 1'b1;
    in_valid = 1'b0;
    {func, domain, device_key, channel, event_code, inline_flag, has_handler, route_bits,
     static_action, dynamic_action, user_flag, slot_id} = '0;

    dir_rows.push_back(dir_row(pub_q(32'h0), 1'b1, ST_NO_MATCH, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd0, 1'b0), 1'b1, ST_NOT_FOUND, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd255, 1'b0), 1'b1, ST_NOT_FOUND, 5'd0));
    // no handler, route or action
    dir_rows.push_back(dir_row(sub_q(32'h0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
                               1'b1, ST_INVALID, 5'd0));
    // inline with a route
    dir_rows.push_back(dir_row(sub_q(32'h0, 1'b1, 1'b1, 8'h01, 8'h00, 8'h00, 1'b0),
                               1'b1, ST_INVALID, 5'd0));
    // inline without a handler
    dir_rows.push_back(dir_row(sub_q(32'h0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h05, 1'b0),
                               1'b1, ST_INVALID, 5'd0));
    // user entry with a handler
    dir_rows.push_back(dir_row(sub_q(32'h0, 1'b0, 1'b1, 8'h01, 8'h00, 8'h00, 1'b1),
                               1'b1, ST_INVALID, 5'd0));
    dir_rows.push_back(dir_row(sub_q(32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0),
                               1'b1, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(sub_q(32'h0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
                               1'b1, ST_OK, 5'd1));
    dir_rows.push_back(dir_row(sub_q(32'h0, 1'b0, 1'b0, 8'h01, 8'h00, 8'h00, 1'b1),
                               1'b1, ST_OK, 5'd2));
    dir_rows.push_back(dir_row(pub_q(32'h0), 1'b0, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(pub_q(32'hFFFF_FFFF), 1'b0, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd0, 1'b1), 1'b1, ST_PROTECTED, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd2, 1'b1), 1'b1, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(sub_q(32'h0101_0101, 1'b0, 1'b0, 8'h02, 8'h00, 8'h00, 1'b1),
                               1'b1, ST_OK, 5'd2));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB_ALL, 8'd0, 1'b0), 1'b1, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd2, 1'b0), 1'b1, ST_NOT_FOUND, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd1, 1'b0), 1'b1, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(pub_q(32'h0), 1'b0, ST_OK, 5'd0));
    dir_rows.push_back(dir_row(unsub_q(FN_UNSUB, 8'd31, 1'b0), 1'b1, ST_NOT_FOUND, 5'd0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) send_item(dir_rows[k].q, dir_rows[k].typed, dir_rows[k].want);

    // fill every slot with all-wildcard entries, overflow once, then publish to all
    while (shadow_used != '1) begin
      q = sub_q(32'hFFFF_FFFF, 1'b0, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      if ($urandom_range(0, 1))
        q = sub_q(32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(q, 1'b0, '0);
    end
    send_item(sub_q(32'h0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, '0);
    send_item(pub_q($urandom), 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(rand_query(), 1'b0, '0);
    end
    in_valid = 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("event_subscription_match_table_tb: PASS");
    else
      $display("event_subscription_match_table_tb: FAIL");
    $finish;
  end

endmodule
